@@ hdl/cms_pkg.sv @@
package cms_pkg;

   localparam int unsigned TimeWidth  = 16;
   localparam int unsigned FaultWidth = 3;
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   typedef enum logic [4:0] {
      MODE_BOOT         = 5'd0,
      MODE_SELF_CHECK   = 5'd1,
      MODE_CALIBRATION  = 5'd2,
      MODE_SAFE_READY   = 5'd3,
      MODE_ARMED        = 5'd4,
      MODE_GROUND_TRACK = 5'd5,
      MODE_CANDIDATE    = 5'd6,
      MODE_PRECHARGE    = 5'd7,
      MODE_APPROACH     = 5'd8,
      MODE_TRANS_UP     = 5'd9,
      MODE_WALL         = 5'd10,
      MODE_CYLINDER     = 5'd11,
      MODE_TRANS_DOWN   = 5'd12,
      MODE_RECOVERY     = 5'd13,
      MODE_SEESAW       = 5'd14,
      MODE_LOCKOUT      = 5'd15,
      MODE_GROUND_FAULT = 5'd16,
      MODE_WALL_HOLD    = 5'd17,
      MODE_HARD_FAULT   = 5'd18,
      MODE_FINISHED     = 5'd19
   } mode_type;

   // fault bit positions
   localparam int unsigned FaultStale   = 0;
   localparam int unsigned FaultLockout = 1;
   localparam int unsigned FaultPower   = 2;

   localparam logic [2:0] SURF_GROUND = 3'd1;
   localparam logic [2:0] SURF_UP     = 3'd2;
   localparam logic [2:0] SURF_WALL   = 3'd3;
   localparam logic [2:0] SURF_CYL    = 3'd4;
   localparam logic [2:0] SURF_DOWN   = 3'd5;

   typedef enum logic [1:0] {
      REG_TRANSITION_TIMEOUT = 2'd0,
      REG_PRECHARGE_MIN      = 2'd1,
      REG_GROUND_CONFIRM     = 2'd2,
      REG_WALL_CAPABLE       = 2'd3
   } reg_index_type;

   localparam logic [TimeWidth-1:0] TransitionTimeoutReset = 16'd3000;
   localparam logic [TimeWidth-1:0] PrechargeMinReset      = 16'd500;
   localparam logic [TimeWidth-1:0] GroundConfirmReset     = 16'd500;

   typedef struct packed {
      logic [TimeWidth-1:0] elapsed_ms;
      logic                 supply_good;
      logic                 line_sensor_ok;
      logic                 inertial_fresh;
      logic                 wheel_enc_ok;
      logic                 period_ok;
      logic                 arm_request;
      logic                 suction_authorized;
      logic                 candidate_seen;
      logic [2:0]           surface;
   } req_type;

   typedef struct packed {
      logic [4:0]            mode;
      logic [FaultWidth-1:0] fault_flags;
      logic [TimeWidth-1:0]  time_in_mode_ms;
   } rsp_type;

   typedef struct packed {
      logic [TimeWidth-1:0] trans_timeout_ms;
      logic [TimeWidth-1:0] precharge_min_ms;
      logic [TimeWidth-1:0] ground_confirm_ms;
      logic                 wall_capable;
   } cfg_type;

   typedef struct packed {
      mode_type              mode;
      logic [FaultWidth-1:0] fault;
      logic [TimeWidth-1:0]  timer;
   } state_type;

endpackage

@@ hdl/cms_csr.sv @@
module cms_csr
   import cms_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index = reg_index_type'(csr_paddr[3:2]);
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_TRANSITION_TIMEOUT: cfg_in.trans_timeout_ms  = csr_pwdata[TimeWidth-1:0];
            REG_PRECHARGE_MIN:      cfg_in.precharge_min_ms  = csr_pwdata[TimeWidth-1:0];
            REG_GROUND_CONFIRM:     cfg_in.ground_confirm_ms = csr_pwdata[TimeWidth-1:0];
            REG_WALL_CAPABLE:       cfg_in.wall_capable      = csr_pwdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trans_timeout_ms  <= TransitionTimeoutReset;
         cfg_ff.precharge_min_ms  <= PrechargeMinReset;
         cfg_ff.ground_confirm_ms <= GroundConfirmReset;
         cfg_ff.wall_capable      <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_TRANSITION_TIMEOUT:
            csr_prdata = {{(CsrDataWidth-TimeWidth){1'b0}}, cfg_ff.trans_timeout_ms};
         REG_PRECHARGE_MIN:
            csr_prdata = {{(CsrDataWidth-TimeWidth){1'b0}}, cfg_ff.precharge_min_ms};
         REG_GROUND_CONFIRM:
            csr_prdata = {{(CsrDataWidth-TimeWidth){1'b0}}, cfg_ff.ground_confirm_ms};
         REG_WALL_CAPABLE:
            csr_prdata = {{(CsrDataWidth-1){1'b0}}, cfg_ff.wall_capable};
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/cms_next.sv @@
module cms_next
   import cms_pkg::*;
(
   input  state_type cur,
   input  req_type   req,
   input  cfg_type   cfg,
   output state_type nxt
);

   logic                 ready, ground, up, wall, cyl, down, late;
   logic                 cand, stale;
   logic [TimeWidth-1:0] timer_sum;
   logic                 change;
   mode_type             target;

   always_comb begin
      ready  = req.line_sensor_ok & req.inertial_fresh & req.wheel_enc_ok & req.period_ok;
      ground = req.surface == SURF_GROUND;
      up     = (req.surface == SURF_UP) || (req.surface == SURF_WALL);
      wall   = req.surface == SURF_WALL;
      cyl    = req.surface == SURF_CYL;
      down   = (req.surface == SURF_DOWN) || (req.surface == SURF_GROUND);
      cand   = req.candidate_seen;

      timer_sum = cur.timer + req.elapsed_ms;   // wraps
      late      = timer_sum > cfg.trans_timeout_ms;

      nxt    = cur;
      change = 1'b0;
      target = cur.mode;
      stale  = 1'b0;

      unique case (cur.mode)
         MODE_BOOT: begin
            change = 1'b1;
            target = MODE_SELF_CHECK;
         end
         MODE_SELF_CHECK: begin
            change = req.supply_good;
            target = MODE_CALIBRATION;
         end
         MODE_CALIBRATION: begin
            change = ready & ground;
            target = MODE_SAFE_READY;
         end
         MODE_SAFE_READY: begin
            change = req.arm_request & ready;
            target = MODE_ARMED;
         end
         MODE_ARMED: begin
            change = ready & ground;
            target = MODE_GROUND_TRACK;
         end
         MODE_GROUND_TRACK: begin
            change = req.suction_authorized & ready & cand;
            if (cfg.wall_capable) begin
               target = MODE_CANDIDATE;
            end else begin
               target = MODE_LOCKOUT;
               nxt.fault[FaultLockout] = cur.fault[FaultLockout] | change;
            end
         end
         MODE_CANDIDATE: begin
            stale  = !ready || !cand;
            change = !stale;
            target = MODE_PRECHARGE;
         end
         MODE_PRECHARGE: begin
            stale  = !ready || !cand || late;
            change = !stale && (timer_sum >= cfg.precharge_min_ms);
            target = MODE_APPROACH;
         end
         MODE_APPROACH: begin
            stale  = !ready || (!cand && !up) || late;
            change = !stale && up;
            target = MODE_TRANS_UP;
         end
         MODE_TRANS_UP: begin
            stale  = !ready || late;
            change = !stale && wall;
            target = MODE_WALL;
         end
         MODE_WALL: begin
            stale  = !ready;
            change = !stale && (cyl || down);
            target = cyl ? MODE_CYLINDER : MODE_TRANS_DOWN;
         end
         MODE_CYLINDER: begin
            stale  = !ready;
            change = !stale && (wall || down);
            target = wall ? MODE_WALL : MODE_TRANS_DOWN;
         end
         MODE_TRANS_DOWN: begin
            stale  = !ready || late;
            change = !stale && ground;
            target = MODE_RECOVERY;
         end
         MODE_RECOVERY: begin
            stale  = !ready || up || cyl;
            change = !stale && ground && (timer_sum >= cfg.ground_confirm_ms);
            target = MODE_GROUND_TRACK;
         end
         MODE_SEESAW: begin
            change = ground;
            target = MODE_GROUND_TRACK;
         end
         MODE_LOCKOUT, MODE_GROUND_FAULT, MODE_WALL_HOLD, MODE_HARD_FAULT,
         MODE_FINISHED: begin
            change = 1'b0;
         end
         default: begin
            // corrupted mode code
            change = 1'b1;
            target = MODE_HARD_FAULT;
            nxt.fault[FaultPower] = 1'b1;
         end
      endcase

      nxt.fault[FaultStale] = cur.fault[FaultStale] | stale;
      nxt.mode  = change ? target : cur.mode;
      nxt.timer = change ? '0 : timer_sum;
   end

endmodule

@@ hdl/climb_mode_sequencer_top.sv @@
// Operating-mode sequencer for a wall-climbing vehicle.
// req channel: one beat per control tick (elapsed time, health flags, operator
// inputs, candidate flag, surface class). rsp channel: one beat per req beat
// with the mode, sticky fault flags and time in mode after that tick.
// A beat moves when valid is high and stall is low.
// The rsp beat of a tick appears in the cycle after it is taken: the next-state logic
// sits between the req port and the state registers, which are also the rsp register.
// Throughput is one beat per cycle; req_stall is raised only while an rsp beat is held
// by rsp_stall, so a new tick is taken in the same cycle the pending result leaves.
// Tuning registers sit on the csr_ APB port (byte address 4 * index); the user must
// write them only while the sequencer is idle, the block itself does not enforce it.
// Reset (synchronous) puts the mode in boot, clears faults and the timer, loads
// the register defaults and drops rsp_valid. Faults clear only by reset.
module climb_mode_sequencer_top
   import cms_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_payload,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   cfg_type   cfg;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   cms_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cms_next u_next (
      .cur (state_ff),
      .req (req_payload),
      .cfg (cfg),
      .nxt (state_in)
   );

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode  <= MODE_BOOT;
         state_ff.fault <= '0;
         state_ff.timer <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_payload.mode            = state_ff.mode;
   assign rsp_payload.fault_flags     = state_ff.fault;
   assign rsp_payload.time_in_mode_ms = state_ff.timer;

endmodule

@@ hdl/cms_checker.sv @@
module cms_checker
   import cms_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // a held result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   // every accepted tick yields a result beat in the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted tick produced no result");

   a_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (rsp_payload.fault_flags & $past(rsp_payload.fault_flags))
                    == $past(rsp_payload.fault_flags))
      else $error("sticky fault bit cleared");

   a_mode_change_clears_timer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) && rsp_payload.mode != $past(rsp_payload.mode)
      |-> rsp_payload.time_in_mode_ms == '0)
      else $error("timer not cleared on mode change");

   a_power_fault_terminal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.fault_flags[FaultPower]
      |-> rsp_payload.mode == MODE_HARD_FAULT)
      else $error("hard power fault outside hard fault mode");

endmodule

bind climb_mode_sequencer_top cms_checker u_cms_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

@@ tb/climb_mode_sequencer_top_tb.sv @@
`timescale 1ns / 100ps

module climb_mode_sequencer_top_tb
   import cms_pkg::*;
();

   localparam int WatchdogLimit = 1000;
   localparam int LongHoldCycles = 80;

   // flag byte of a tick: power, line, imu, encoder, period, arm, auth, candidate
   localparam logic [7:0] Healthy = 8'hF8;
   localparam logic [7:0] ArmBit  = 8'h04;
   localparam logic [7:0] AuthBit = 8'h02;
   localparam logic [7:0] CandBit = 8'h01;

   localparam logic [2:0] SurfUnknown = 3'd0;
   localparam logic [2:0] SurfNone    = 3'd6;
   localparam logic [2:0] SurfNoneHi  = 3'd7;

   class mode_scoreboard;
      mode_type              mode;
      logic [FaultWidth-1:0] faults;
      logic [TimeWidth-1:0]  timer;
      logic [TimeWidth-1:0]  timeout_ms;
      logic [TimeWidth-1:0]  precharge_ms;
      logic [TimeWidth-1:0]  confirm_ms;
      logic                  wall_ok;
      rsp_type               expected_q[$];
      int                    errors;

      function new();
         mode = MODE_BOOT;
         faults = '0;
         timer = '0;
         timeout_ms = TransitionTimeoutReset;
         precharge_ms = PrechargeMinReset;
         confirm_ms = GroundConfirmReset;
         wall_ok = 1'b1;
         errors = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [CsrDataWidth-1:0] data);
         case (idx)
            REG_TRANSITION_TIMEOUT: timeout_ms = data[TimeWidth-1:0];
            REG_PRECHARGE_MIN:      precharge_ms = data[TimeWidth-1:0];
            REG_GROUND_CONFIRM:     confirm_ms = data[TimeWidth-1:0];
            REG_WALL_CAPABLE:       wall_ok = data[0];
            default: ;
         endcase
      endfunction

      function void enter(mode_type m);
         mode = m;
         timer = '0;
      endfunction

      function void note_tick(req_type t);
         logic    ready, cand, ground, up, on_wall, cyl, down, late;
         rsp_type e;
         ready = t.line_sensor_ok & t.inertial_fresh & t.wheel_enc_ok & t.period_ok;
         cand = t.candidate_seen;
         ground = t.surface == SURF_GROUND;
         up = (t.surface == SURF_UP) || (t.surface == SURF_WALL);
         on_wall = t.surface == SURF_WALL;
         cyl = t.surface == SURF_CYL;
         down = (t.surface == SURF_DOWN) || ground;
         timer = timer + t.elapsed_ms;
         late = timer > timeout_ms;
         case (mode)
            MODE_BOOT: enter(MODE_SELF_CHECK);
            MODE_SELF_CHECK: if (t.supply_good) enter(MODE_CALIBRATION);
            MODE_CALIBRATION: if (ready && ground) enter(MODE_SAFE_READY);
            MODE_SAFE_READY: if (t.arm_request && ready) enter(MODE_ARMED);
            MODE_ARMED: if (ready && ground) enter(MODE_GROUND_TRACK);
            MODE_GROUND_TRACK: begin
               if (t.suction_authorized && ready && cand) begin
                  if (wall_ok) begin
                     enter(MODE_CANDIDATE);
                  end else begin
                     faults[FaultLockout] = 1'b1;
                     enter(MODE_LOCKOUT);
                  end
               end
            end
            MODE_CANDIDATE: begin
               if (!ready || !cand) faults[FaultStale] = 1'b1;
               else enter(MODE_PRECHARGE);
            end
            MODE_PRECHARGE: begin
               if (!ready || !cand || late) faults[FaultStale] = 1'b1;
               else if (timer >= precharge_ms) enter(MODE_APPROACH);
            end
            MODE_APPROACH: begin
               if (!ready || (!cand && !up) || late) faults[FaultStale] = 1'b1;
               else if (up) enter(MODE_TRANS_UP);
            end
            MODE_TRANS_UP: begin
               if (!ready || late) faults[FaultStale] = 1'b1;
               else if (on_wall) enter(MODE_WALL);
            end
            MODE_WALL: begin
               if (!ready) faults[FaultStale] = 1'b1;
               else if (cyl) enter(MODE_CYLINDER);
               else if (down) enter(MODE_TRANS_DOWN);
            end
            MODE_CYLINDER: begin
               if (!ready) faults[FaultStale] = 1'b1;
               else if (on_wall) enter(MODE_WALL);
               else if (down) enter(MODE_TRANS_DOWN);
            end
            MODE_TRANS_DOWN: begin
               if (!ready || late) faults[FaultStale] = 1'b1;
               else if (ground) enter(MODE_RECOVERY);
            end
            MODE_RECOVERY: begin
               if (!ready || up || cyl) faults[FaultStale] = 1'b1;
               else if (timer >= confirm_ms && ground) enter(MODE_GROUND_TRACK);
            end
            MODE_SEESAW: if (ground) enter(MODE_GROUND_TRACK);
            MODE_LOCKOUT, MODE_GROUND_FAULT, MODE_WALL_HOLD, MODE_HARD_FAULT,
            MODE_FINISHED: ;
            default: begin
               faults[FaultPower] = 1'b1;
               enter(MODE_HARD_FAULT);
            end
         endcase
         e.mode = mode;
         e.fault_flags = faults;
         e.time_in_mode_ms = timer;
         expected_q.push_back(e);
      endfunction

      task report(string msg);
         $display("[%0t] %s", $realtime, msg);
         errors++;
      endtask

      task check_result(rsp_type r);
         rsp_type e;
         if (expected_q.size() == 0) begin
            report($sformatf("result beat with nothing pending: mode %0d", r.mode));
            return;
         end
         e = expected_q.pop_front();
         if (r.mode !== e.mode)
            report($sformatf("mode %0d, want %0d", r.mode, e.mode));
         if (r.fault_flags !== e.fault_flags)
            report($sformatf("fault_flags %b, want %b", r.fault_flags, e.fault_flags));
         if (r.time_in_mode_ms !== e.time_in_mode_ms)
            report($sformatf("time_in_mode_ms %0d, want %0d",
                             r.time_in_mode_ms, e.time_in_mode_ms));
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_payload;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   mode_scoreboard sb = new();
   int             ticks_noted = 0;
   bit             calm = 1'b0;
   int             stall_left = 0;
   bit             long_done = 1'b0;
   int             quiet_cycles = 0;

   climb_mode_sequencer_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly short pauses, now and then a long one
   function automatic int pause_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type tick(logic [15:0] ms, logic [7:0] flags, logic [2:0] surf);
      return {ms, flags, surf};
   endfunction

   // elapsed time that lands the mode timer somewhere in [lo, hi]
   function automatic logic [15:0] stride_to(logic [15:0] lo, logic [15:0] hi);
      int unsigned target;
      target = $urandom_range(hi, lo);
      return target[15:0] - sb.timer;
   endfunction

   // Mostly ticks that push the current mode forward, with random content
   // and the odd broken flag; the rest is plain noise.
   function automatic req_type next_tick();
      req_type     t;
      logic [31:0] raw;
      logic [15:0] hi;
      raw = $urandom;
      if ($urandom_range(0, 99) < 15) begin
         t = raw[$bits(req_type)-1:0];
         return t;
      end
      t.elapsed_ms = ($urandom_range(0, 19) == 0) ? raw[31:16] : {10'd0, raw[21:16]};
      t.supply_good = $urandom_range(0, 15) != 0;
      t.line_sensor_ok = $urandom_range(0, 15) != 0;
      t.inertial_fresh = $urandom_range(0, 15) != 0;
      t.wheel_enc_ok = $urandom_range(0, 15) != 0;
      t.period_ok = $urandom_range(0, 15) != 0;
      t.arm_request = $urandom_range(0, 7) != 0;
      t.suction_authorized = $urandom_range(0, 7) != 0;
      t.candidate_seen = $urandom_range(0, 7) != 0;
      t.surface = raw[2:0];
      if ($urandom_range(0, 9) != 0) begin
         case (sb.mode)
            MODE_CALIBRATION, MODE_ARMED, MODE_TRANS_DOWN: t.surface = SURF_GROUND;
            MODE_APPROACH: t.surface = raw[3] ? SURF_WALL : SURF_UP;
            MODE_TRANS_UP: t.surface = SURF_WALL;
            MODE_WALL, MODE_CYLINDER: begin
               case (raw[4:3])
                  2'd0:    t.surface = SURF_WALL;
                  2'd1:    t.surface = SURF_CYL;
                  2'd2:    t.surface = SURF_DOWN;
                  default: t.surface = SURF_GROUND;
               endcase
            end
            MODE_PRECHARGE: begin
               if (raw[5] && sb.precharge_ms <= sb.timeout_ms)
                  t.elapsed_ms = stride_to(sb.precharge_ms, sb.timeout_ms);
            end
            MODE_RECOVERY: begin
               t.surface = SURF_GROUND;
               if (raw[5]) begin
                  hi = (sb.confirm_ms > 16'hFEFF) ? 16'hFFFF : sb.confirm_ms + 16'd256;
                  t.elapsed_ms = stride_to(sb.confirm_ms, hi);
               end
            end
            default: ;
         endcase
      end
      return t;
   endfunction

   task automatic send_tick(req_type t);
      int gap;
      req_payload <= t;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_tick(t);
      ticks_noted++;
      gap = 0;
      if (!calm && $urandom_range(0, 2) == 0) gap = pause_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // psel stays up between back-to-back writes; the caller drops it
   task automatic csr_write(reg_index_type idx, logic [CsrDataWidth-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // upper data bits carry junk the block must drop
   task automatic apply_settings(logic [15:0] timeout, logic [15:0] precharge,
                                 logic [15:0] confirm, logic wall);
      logic [31:0] junk;
      junk = $urandom;
      csr_write(REG_TRANSITION_TIMEOUT, {junk[31:16], timeout});
      csr_write(REG_PRECHARGE_MIN, {junk[15:0], precharge});
      csr_write(REG_GROUND_CONFIRM, {junk[23:8], confirm});
      csr_write(REG_WALL_CAPABLE, {junk[30:0], wall});
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
      if (stall_left > 0) stall_left--;
      else if (!long_done && ticks_noted >= 200) begin
         // long hold-off: the single result slot fills and req_stall must rise
         stall_left = LongHoldCycles;
         long_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) stall_left = pause_len();
      rsp_stall <= (stall_left > 0);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("climb_mode_sequencer_top_tb: done, errors");
         $finish;
      end
   end

   initial begin
      int unsigned lim_a, lim_b, lim_c;
      int          n_items;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // walk the whole ground-wall-ground loop under reset settings
      send_tick(tick(16'hFFFF, 8'h00, SurfNoneHi));
      send_tick(tick(16'd0, 8'h7F, SurfNone));
      send_tick(tick(16'd10, Healthy, SurfUnknown));
      send_tick(tick(16'd10, 8'hF0, SURF_GROUND));
      send_tick(tick(16'd10, Healthy, SurfNone));
      send_tick(tick(16'd10, Healthy, SURF_GROUND));
      send_tick(tick(16'd10, Healthy, SURF_GROUND));
      send_tick(tick(16'd10, Healthy | ArmBit, SurfUnknown));
      send_tick(tick(16'd10, Healthy, SURF_GROUND));
      send_tick(tick(16'd10, Healthy | AuthBit, SurfNoneHi));
      send_tick(tick(16'd10, Healthy | AuthBit | CandBit, SurfUnknown));
      send_tick(tick(16'd10, Healthy, SurfUnknown));
      send_tick(tick(16'd10, Healthy | CandBit, SurfUnknown));
      send_tick(tick(16'd100, Healthy | CandBit, SurfUnknown));
      send_tick(tick(16'd450, Healthy | CandBit, SurfUnknown));
      send_tick(tick(16'd5, Healthy, SurfUnknown));
      send_tick(tick(16'd5, Healthy, SURF_UP));
      send_tick(tick(16'd5, Healthy, SURF_WALL));
      send_tick(tick(16'd5, Healthy, SURF_CYL));
      send_tick(tick(16'd5, Healthy, SURF_WALL));
      send_tick(tick(16'd5, Healthy, SURF_DOWN));
      send_tick(tick(16'd5, Healthy, SURF_GROUND));
      send_tick(tick(16'hFFFF, Healthy, SURF_GROUND));
      send_tick(tick(16'hFFFF, 8'hFF, SurfUnknown));
      drain();

      // lockout is terminal, so wall_capable low comes last
      for (int p = 0; p < 5; p++) begin
         lim_a = $urandom_range(4000, 100);
         lim_b = $urandom_range(1200, 0);
         lim_c = $urandom_range(1200, 0);
         case (p)
            0: apply_settings(16'hFFFF, 16'd0, 16'd0, 1'b1);
            1: apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
            4: apply_settings(lim_a[15:0], lim_b[15:0], lim_c[15:0], 1'b0);
            default: apply_settings(lim_a[15:0], lim_b[15:0], lim_c[15:0], 1'b1);
         endcase
         calm = (p == 1);
         n_items = (p == 1) ? 40 : (p == 4) ? 60 : 95;
         for (int i = 0; i < n_items; i++) send_tick(next_tick());
         drain();
      end

      repeat (4) @(posedge clock);
      if (sb.expected_q.size() != 0) sb.report("results still pending at end of run");
      if (sb.errors == 0) begin
         $display("climb_mode_sequencer_top_tb: done, clean");
      end else begin
         $display("climb_mode_sequencer_top_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/cms_pkg.sv
hdl/cms_csr.sv
hdl/cms_next.sv
hdl/climb_mode_sequencer_top.sv
hdl/cms_checker.sv
tb/climb_mode_sequencer_top_tb.sv
